// ===== design/lcal_pkg.sv =====
// Shared types and constants for the lowest common ancestor lifting unit.
// Used by lcal_ctrl, lcal_dp and the top level; no dependencies.
package lcal_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int LIFT_LEVELS = 11;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int LVL_W       = $clog2(LIFT_LEVELS);
    localparam int DEPTH_W     = 11;
    localparam int CMP_W       = DEPTH_W + 2;
    localparam int MSB_W       = $clog2(DEPTH_W - 1);
    localparam int ANC_DEPTH   = MAX_NODES * LIFT_LEVELS;
    localparam int ANC_AW      = LVL_W + NODE_W;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } t_lcal_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_BLD_RD1,
        ST_BLD_RD2,
        ST_BLD_WR,
        ST_Q_DEP,
        ST_Q_SORT,
        ST_Q_UP_RD,
        ST_Q_UP_EV,
        ST_Q_EQ,
        ST_Q_JMP_RD,
        ST_Q_JMP_EV,
        ST_Q_FIN_RD,
        ST_Q_FIN_EV,
        ST_DONE
    } t_lcal_state;

    // one ancestor table entry: present flag plus node number
    typedef struct packed {
        logic              present;
        logic [NODE_W-1:0] node;
    } t_lcal_anc;

    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic load_wr;
        logic bld_rd_first;
        logic bld_rd_second;
        logic bld_wr;
        logic dep_rd;
        logic sort;
        logic up_rd;
        logic up_eval;
        logic lvl_reload;
        logic jmp_rd;
        logic jmp_eval;
        logic fin_rd;
        logic fin_eval;
        logic res_ack;
        logic res_from_u;
        logic out_load;
    } t_lcal_cmd;

    typedef struct packed {
        logic clr_last;
        logic bld_empty;
        logic bld_last;
        logic no_lift;
        logic lvl_zero;
        logic u_eq_v;
    } t_lcal_status;

    // index of the highest set bit; zero when none is set
    function automatic logic [MSB_W-1:0] lcal_msb(input logic [DEPTH_W-2:0] val);
        logic [MSB_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < DEPTH_W - 1; k++) begin
            if (val[k]) begin
                idx = MSB_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/lcal_ctrl.sv =====
// Sequencer for the lowest common ancestor lifting unit.
// Depends on lcal_pkg; drives lcal_dp through t_lcal_cmd and reads t_lcal_status.
module lcal_ctrl
    import lcal_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  t_lcal_op     i_op,
    input  logic         i_out_ready,
    input  t_lcal_status i_status,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_lcal_cmd    o_cmd
);

    t_lcal_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic        out_free;

    // output register can take a new result
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_LOAD:  n_state = ST_LOAD;
                        OP_BUILD: n_state = i_status.bld_empty ? ST_DONE : ST_BLD_RD1;
                        OP_QUERY: n_state = ST_Q_DEP;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_LOAD:     n_state = ST_DONE;
            ST_BLD_RD1:  n_state = ST_BLD_RD2;
            ST_BLD_RD2:  n_state = ST_BLD_WR;
            ST_BLD_WR:   n_state = i_status.bld_last ? ST_DONE : ST_BLD_RD1;
            ST_Q_DEP:    n_state = ST_Q_SORT;
            ST_Q_SORT:   n_state = ST_Q_UP_RD;
            ST_Q_UP_RD:  n_state = i_status.no_lift ? ST_Q_EQ : ST_Q_UP_EV;
            ST_Q_UP_EV:  n_state = i_status.lvl_zero ? ST_Q_EQ : ST_Q_UP_RD;
            ST_Q_EQ: begin
                if (i_status.u_eq_v) begin
                    n_state = ST_DONE;
                end else if (i_status.no_lift) begin
                    n_state = ST_Q_FIN_RD;
                end else begin
                    n_state = ST_Q_JMP_RD;
                end
            end
            ST_Q_JMP_RD: n_state = ST_Q_JMP_EV;
            ST_Q_JMP_EV: n_state = i_status.lvl_zero ? ST_Q_FIN_RD : ST_Q_JMP_RD;
            ST_Q_FIN_RD: n_state = ST_Q_FIN_EV;
            ST_Q_FIN_EV: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_CLEAR:    o_cmd.clr_wr = 1'b1;
            ST_IDLE: begin
                o_cmd.capture = i_in_valid;
                o_cmd.res_ack = i_in_valid && (i_op != OP_QUERY);
            end
            ST_LOAD:     o_cmd.load_wr = 1'b1;
            ST_BLD_RD1:  o_cmd.bld_rd_first = 1'b1;
            ST_BLD_RD2:  o_cmd.bld_rd_second = 1'b1;
            ST_BLD_WR:   o_cmd.bld_wr = 1'b1;
            ST_Q_DEP:    o_cmd.dep_rd = 1'b1;
            ST_Q_SORT:   o_cmd.sort = 1'b1;
            ST_Q_UP_RD:  o_cmd.up_rd = !i_status.no_lift;
            ST_Q_UP_EV:  o_cmd.up_eval = 1'b1;
            ST_Q_EQ: begin
                o_cmd.lvl_reload = 1'b1;
                o_cmd.res_from_u = i_status.u_eq_v;
            end
            ST_Q_JMP_RD: o_cmd.jmp_rd = 1'b1;
            ST_Q_JMP_EV: o_cmd.jmp_eval = 1'b1;
            ST_Q_FIN_RD: o_cmd.fin_rd = 1'b1;
            ST_Q_FIN_EV: o_cmd.fin_eval = 1'b1;
            ST_DONE:     o_cmd.out_load = out_free;
            default:     o_cmd = '0;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/lcal_dp.sv =====
// Datapath of the lowest common ancestor lifting unit: ancestor table,
// depth store, walk registers and result registers. Depends on lcal_pkg.
module lcal_dp
    import lcal_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lcal_cmd                 i_cmd,
    input  logic [NODE_W-1:0]         i_node_count,
    input  logic [NODE_W-1:0]         i_node_a,
    input  logic [NODE_W-1:0]         i_node_b,
    input  logic [NODE_W-1:0]         i_parent_node,
    input  logic                      i_parent_absent,
    input  logic signed [DEPTH_W-1:0] i_node_depth,
    output t_lcal_status              o_status,
    output logic                      o_answer_kind,
    output logic [NODE_W-1:0]         o_ancestor,
    output logic                      o_ancestor_absent
);

    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LIFT_LEVELS - 1);

    // storage
    t_lcal_anc                 r_anc_mem [0:ANC_DEPTH-1];
    logic signed [DEPTH_W-1:0] r_dep_mem [0:MAX_NODES-1];
    t_lcal_anc                 r_anc_rd0, r_anc_rd1;
    logic signed [DEPTH_W-1:0] r_dep_rd0, r_dep_rd1;

    // captured item
    logic [NODE_W-1:0]         r_a, r_b, r_par;
    logic                      r_par_abs;
    logic signed [DEPTH_W-1:0] r_depth;

    // walk and sequencing registers
    t_lcal_anc                 r_u, r_v;
    logic signed [DEPTH_W-1:0] r_dv;
    logic [LVL_W-1:0]          r_lvl, r_lg;
    logic                      r_no_lift;
    logic [LVL_W-1:0]          r_lv;
    logic [NODE_W-1:0]         r_j;
    logic [ANC_AW-1:0]         r_clr_addr;

    // result and output registers
    t_lcal_anc                 r_res;
    logic                      r_res_kind;
    logic                      r_out_kind;
    logic [NODE_W-1:0]         r_out_anc;
    logic                      r_out_abs;

    // memory port signals
    logic                      anc_we, anc_re0, anc_re1;
    logic [ANC_AW-1:0]         anc_waddr, anc_raddr0, anc_raddr1;
    t_lcal_anc                 anc_wdata;
    logic                      dep_re0;
    logic [NODE_W-1:0]         dep_raddr0;

    // sort / lift evaluation
    logic                      swap;
    logic signed [DEPTH_W-1:0] sort_du, sort_dv;
    logic [MSB_W-1:0]          sort_msb;
    logic [LVL_W-1:0]          sort_lg;
    logic signed [DEPTH_W-1:0] up_cur;
    logic signed [CMP_W-1:0]   up_lhs, up_rhs, up_step;
    t_lcal_anc                 pu, pv;

    // ---------------- memory ports ----------------
    always_comb begin
        anc_we    = i_cmd.clr_wr || i_cmd.load_wr || i_cmd.bld_wr;
        anc_waddr = r_clr_addr;
        anc_wdata = '0;
        if (i_cmd.load_wr) begin
            anc_waddr = {LVL_W'(0), r_a};
            anc_wdata = r_par_abs ? t_lcal_anc'('0) : t_lcal_anc'({1'b1, r_par});
        end else if (i_cmd.bld_wr) begin
            anc_waddr = {r_lv, r_j};
            // a none lower-level ancestor yields none
            anc_wdata = r_anc_rd0.present ? r_anc_rd1 : t_lcal_anc'('0);
        end
    end

    always_comb begin
        anc_re0 = i_cmd.bld_rd_first || i_cmd.up_rd || i_cmd.jmp_rd || i_cmd.fin_rd;
        anc_re1 = i_cmd.bld_rd_second || i_cmd.jmp_rd;
        if (i_cmd.bld_rd_first) begin
            anc_raddr0 = {r_lv - LVL_W'(1), r_j};
        end else if (i_cmd.fin_rd) begin
            anc_raddr0 = {LVL_W'(0), r_u.node};
        end else begin
            anc_raddr0 = {r_lvl, r_u.node};
        end
        if (i_cmd.bld_rd_second) begin
            anc_raddr1 = {r_lv - LVL_W'(1), r_anc_rd0.node};
        end else begin
            anc_raddr1 = {r_lvl, r_v.node};
        end
        dep_re0    = i_cmd.dep_rd || i_cmd.up_rd;
        dep_raddr0 = i_cmd.dep_rd ? r_a : r_u.node;
    end

    always_ff @(posedge i_clk) begin
        if (anc_we) begin
            r_anc_mem[anc_waddr] <= anc_wdata;
        end
        if (anc_re0) begin
            r_anc_rd0 <= r_anc_mem[anc_raddr0];
        end
        if (anc_re1) begin
            r_anc_rd1 <= r_anc_mem[anc_raddr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_dep_mem[r_a] <= r_depth;
        end
        if (dep_re0) begin
            r_dep_rd0 <= r_dep_mem[dep_raddr0];
        end
        if (i_cmd.dep_rd) begin
            r_dep_rd1 <= r_dep_mem[r_b];
        end
    end

    // ---------------- clearing pass and build counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_lv       <= LVL_W'(1);
            r_j        <= NODE_W'(1);
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + ANC_AW'(1);
            end
            if (i_cmd.capture) begin
                r_lv <= LVL_W'(1);
                r_j  <= NODE_W'(1);
            end else if (i_cmd.bld_wr) begin
                if (r_j == i_node_count) begin
                    r_j  <= NODE_W'(1);
                    r_lv <= r_lv + LVL_W'(1);
                end else begin
                    r_j <= r_j + NODE_W'(1);
                end
            end
        end
    end

    // ---------------- captured item ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a       <= i_node_a;
            r_b       <= i_node_b;
            r_par     <= i_parent_node;
            r_par_abs <= i_parent_absent;
            r_depth   <= i_node_depth;
        end
    end

    // ---------------- query walk ----------------
    always_comb begin
        swap     = (r_dep_rd0 <= r_dep_rd1);
        sort_du  = swap ? r_dep_rd1 : r_dep_rd0;
        sort_dv  = swap ? r_dep_rd0 : r_dep_rd1;
        sort_msb = lcal_msb(sort_du[DEPTH_W-2:0]);
        if (int'(sort_msb) > LIFT_LEVELS - 1) begin
            sort_lg = LAST_LVL;
        end else begin
            sort_lg = LVL_W'(sort_msb);
        end

        // a none node reads depth -1
        up_cur  = r_u.present ? r_dep_rd0 : DEPTH_W'(-1);
        up_step = CMP_W'(1) << r_lvl;
        up_lhs  = {{(CMP_W - DEPTH_W){up_cur[DEPTH_W-1]}}, up_cur} - up_step;
        up_rhs  = {{(CMP_W - DEPTH_W){r_dv[DEPTH_W-1]}}, r_dv};

        pu = r_u.present ? r_anc_rd0 : t_lcal_anc'('0);
        pv = r_v.present ? r_anc_rd1 : t_lcal_anc'('0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sort) begin
            r_u       <= {1'b1, swap ? r_b : r_a};
            r_v       <= {1'b1, swap ? r_a : r_b};
            r_dv      <= sort_dv;
            r_lvl     <= sort_lg;
            r_lg      <= sort_lg;
            r_no_lift <= sort_du[DEPTH_W-1] || (sort_du == '0);
        end else begin
            if (i_cmd.up_eval && (up_lhs >= up_rhs)) begin
                r_u <= pu;
            end
            if (i_cmd.jmp_eval && pu.present && (pu != pv)) begin
                r_u <= pu;
                r_v <= pv;
            end
            if (i_cmd.lvl_reload) begin
                r_lvl <= r_lg;
            end else if ((i_cmd.up_eval || i_cmd.jmp_eval) && (r_lvl != '0)) begin
                r_lvl <= r_lvl - LVL_W'(1);
            end
        end
    end

    // ---------------- results ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_ack) begin
            r_res      <= '0;
            r_res_kind <= 1'b0;
        end else if (i_cmd.res_from_u) begin
            r_res      <= r_u;
            r_res_kind <= 1'b1;
        end else if (i_cmd.fin_eval) begin
            r_res      <= pu;
            r_res_kind <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind <= r_res_kind;
            r_out_anc  <= r_res.present ? r_res.node : '0;
            r_out_abs  <= r_res_kind && !r_res.present;
        end
    end

    assign o_status.clr_last  = (r_clr_addr == ANC_AW'(ANC_DEPTH - 1));
    assign o_status.bld_empty = (i_node_count == '0);
    assign o_status.bld_last  = (r_j == i_node_count) && (r_lv == LAST_LVL);
    assign o_status.no_lift   = r_no_lift;
    assign o_status.lvl_zero  = (r_lvl == '0);
    assign o_status.u_eq_v    = (r_u == r_v);

    assign o_answer_kind     = r_out_kind;
    assign o_ancestor        = r_out_anc;
    assign o_ancestor_absent = r_out_abs;

endmodule

// ===== design/lowest_common_ancestor_lifting_unit.sv =====
// Lowest common ancestor unit using binary lifting over a host-loaded rooted tree.
// After reset the 11264-entry ancestor table is cleared one entry per cycle, and no
// item is accepted until that pass ends (configuration writes are taken throughout).
// Items are worked one at a time and every item returns one result. A query walks
// from level L, where L is floor(log2) of the greater of the two depths (at most 9);
// it skips the lifting passes when that depth is not positive and ends early when
// the first pass already reaches the other node. The ancestor table has a single
// write port and registered reads. An item stays in ST_DONE while the output
// register is still held. A finished result waits in an output register while the
// next item is accepted. Register node_count is at byte address 0 of the APB port.
// Depends on lcal_pkg, lcal_ctrl and lcal_dp.
module lowest_common_ancestor_lifting_unit
    import lcal_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_operation,
    input  logic [NODE_W-1:0]         i_node_a,
    input  logic [NODE_W-1:0]         i_node_b,
    input  logic [NODE_W-1:0]         i_parent_node,
    input  logic                      i_parent_absent,
    input  logic signed [DEPTH_W-1:0] i_node_depth,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_answer_kind,
    output logic [NODE_W-1:0]         o_ancestor,
    output logic                      o_ancestor_absent,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam logic REG_NODE_COUNT = 1'b0;

    logic [NODE_W-1:0] r_node_count;
    logic              reg_index;
    t_lcal_cmd         cmd;
    t_lcal_status      status;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_W'(1);
        end else if (psel && penable && pwrite && (reg_index == REG_NODE_COUNT)) begin
            r_node_count <= pwdata[NODE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_NODE_COUNT) begin
            prdata = 32'(r_node_count);
        end
    end

    lcal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (t_lcal_op'(i_operation)),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lcal_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_node_count      (r_node_count),
        .i_node_a          (i_node_a),
        .i_node_b          (i_node_b),
        .i_parent_node     (i_parent_node),
        .i_parent_absent   (i_parent_absent),
        .i_node_depth      (i_node_depth),
        .o_status          (status),
        .o_answer_kind     (o_answer_kind),
        .o_ancestor        (o_ancestor),
        .o_ancestor_absent (o_ancestor_absent)
    );

endmodule
